/* design/rsdf_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the resonator sine dac feed
// no dependencies

package rsdf_pkg;

  localparam int COEF_W   = 12;
  localparam int INIT_W   = 12;
  localparam int HIST_W   = 16;
  localparam int WORD_W   = 16;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam int PROD_W   = COEF_W + 1 + HIST_W;
  localparam int DIFF_W   = PROD_W + 1;
  localparam int OFFS_W   = HIST_W + 2;

  localparam logic [COEF_W-1:0]        COEF_RST  = 12'd3500;
  localparam logic signed [INIT_W-1:0] PREV_RST  = -12'sd408;
  localparam logic signed [INIT_W-1:0] OLDER_RST = -12'sd797;
  localparam logic [WORD_W-1:0]        CTRL_RST  = 16'h9001;

  localparam logic signed [OFFS_W-1:0] DAC_MAX_CODE = 18'sd4095;
  localparam logic signed [HIST_W-1:0] HIST_MAX     = 16'sh7fff;
  localparam logic signed [HIST_W-1:0] HIST_MIN     = 16'sh8000;

  typedef enum logic [1:0] {
    REG_COEF       = 2'd0,
    REG_INIT_PREV  = 2'd1,
    REG_INIT_OLDER = 2'd2,
    REG_CTRL_WORD  = 2'd3
  } reg_idx_t;

endpackage

/* design/rsdf_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for tick requests and dac results
// depends on rsdf_pkg

interface rsdf_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface rsdf_out_if;
  import rsdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] dac_word;
  logic              is_control;
  logic              clipped;

  modport source (output valid, output dac_word, output is_control, output clipped,
                  input ready);
  modport sink (input valid, input dac_word, input is_control, input clipped,
                output ready);
endinterface

/* design/resonator_sine_dac_feed.sv */
`timescale 1ns / 1ps
// path: an accepted request is held in the input register, then moves to the result
//   register and drives out_ch; a stalled out_ch holds it in the input register
// throughput: one request per cycle unless out_ch stalls; the recursion closes
//   in one stage (12x16 multiply, shift, subtract, saturate) updating the history
// reset (synchronous, rst_n low): registers return to defaults, history and
//   pending control word reload, both channel stages empty
// depends on rsdf_pkg and rsdf_if

module resonator_sine_dac_feed #(
  parameter int FRAC_BITS  = 11,
  parameter int DAC_OFFSET = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rsdf_in_if.sink                     in_ch,
  rsdf_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rsdf_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [rsdf_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [rsdf_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import rsdf_pkg::*;

  localparam logic signed [OFFS_W-1:0] OFFS = OFFS_W'(DAC_OFFSET);

  // configuration registers
  logic [COEF_W-1:0]        coef_r;
  logic signed [INIT_W-1:0] prev_r;
  logic signed [INIT_W-1:0] older_r;
  logic [WORD_W-1:0]        ctrl_r;

  // oscillator state
  logic signed [HIST_W-1:0] hist_recent_r, hist_recent_nxt;
  logic signed [HIST_W-1:0] hist_older_r, hist_older_nxt;
  logic [WORD_W-1:0]        pend_word_r, pend_word_nxt;
  logic                     pend_ctrl_r;

  // stage registers
  logic              v1_r;
  logic              restart_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic              out_ctrl_r;
  logic              out_clip_r;

  logic advance;
  logic cfg_wr;
  reg_idx_t cfg_idx;

  logic signed [HIST_W-1:0] hr, ho;
  logic [WORD_W-1:0]        pw;
  logic                     pc;
  logic signed [PROD_W-1:0] prod, shifted;
  logic signed [DIFF_W-1:0] diff;
  logic signed [OFFS_W-1:0] offs_sum;
  logic                     clip;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[APB_AW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      REG_COEF:       cfg_prdata = APB_DW'(coef_r);
      REG_INIT_PREV:  cfg_prdata = APB_DW'(unsigned'(prev_r));
      REG_INIT_OLDER: cfg_prdata = APB_DW'(unsigned'(older_r));
      REG_CTRL_WORD:  cfg_prdata = APB_DW'(ctrl_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= COEF_RST;
      prev_r  <= PREV_RST;
      older_r <= OLDER_RST;
      ctrl_r  <= CTRL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COEF:       coef_r  <= cfg_pwdata[COEF_W-1:0];
        REG_INIT_PREV:  prev_r  <= signed'(cfg_pwdata[INIT_W-1:0]);
        REG_INIT_OLDER: older_r <= signed'(cfg_pwdata[INIT_W-1:0]);
        REG_CTRL_WORD:  ctrl_r  <= cfg_pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 holds the request, stage 2 is the result register
  assign advance      = v1_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !v1_r || advance;

  // restart swaps in the reload values before the tick
  always_comb begin
    hr = restart_r ? HIST_W'(prev_r)  : hist_recent_r;
    ho = restart_r ? HIST_W'(older_r) : hist_older_r;
    pw = restart_r ? ctrl_r : pend_word_r;
    pc = restart_r || pend_ctrl_r;
  end

  always_comb begin
    clip     = 1'b0;
    prod     = PROD_W'(signed'({1'b0, coef_r})) * PROD_W'(hr);
    shifted  = prod >>> FRAC_BITS;
    diff     = DIFF_W'(shifted) - DIFF_W'(ho);
    if (diff > DIFF_W'(HIST_MAX)) begin
      hist_recent_nxt = HIST_MAX;
      clip            = 1'b1;
    end else if (diff < DIFF_W'(HIST_MIN)) begin
      hist_recent_nxt = HIST_MIN;
      clip            = 1'b1;
    end else begin
      hist_recent_nxt = diff[HIST_W-1:0];
    end
    hist_older_nxt = hr;
    offs_sum       = OFFS_W'(hist_recent_nxt) + OFFS;
    if (offs_sum < 0) begin
      pend_word_nxt = '0;
      clip          = 1'b1;
    end else if (offs_sum > DAC_MAX_CODE) begin
      pend_word_nxt = DAC_MAX_CODE[WORD_W-1:0];
      clip          = 1'b1;
    end else begin
      pend_word_nxt = offs_sum[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      hist_recent_r <= HIST_W'(PREV_RST);
      hist_older_r  <= HIST_W'(OLDER_RST);
      pend_word_r   <= CTRL_RST;
      pend_ctrl_r   <= 1'b1;
    end else begin
      if (in_ch.ready) begin
        v1_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        hist_recent_r <= hist_recent_nxt;
        hist_older_r  <= hist_older_nxt;
        pend_word_r   <= pend_word_nxt;
        pend_ctrl_r   <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      restart_r <= in_ch.restart;
    end
    if (advance) begin
      out_word_r <= pw;
      out_ctrl_r <= pc;
      out_clip_r <= clip;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.dac_word   = out_word_r;
  assign out_ch.is_control = out_ctrl_r;
  assign out_ch.clipped    = out_clip_r;

  // a restarted tick always sends the control word
  a_restart_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    advance && restart_r |=> out_ch.is_control && out_ch.dac_word == ctrl_r)
    else $error("restart tick did not send the control word");

  // the control word goes out at most once per reload
  a_ctrl_once: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> !pend_ctrl_r)
    else $error("pending control flag survived a tick");

  a_no_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !restart_r && !pend_ctrl_r |=> !out_ch.is_control)
    else $error("sample word flagged as control");

  a_dac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.is_control |-> out_ch.dac_word <= DAC_MAX_CODE[WORD_W-1:0])
    else $error("sample word outside dac range");

endmodule
